FILE: rtl/core/brle_pkg.sv
// ---------------------------------------------------------------------------
// brle_pkg
// shared types and constants of the bitmap rle span decoder
// ---------------------------------------------------------------------------
package brle_pkg;

  localparam int COL_W   = 13;
  localparam int COLOR_W = 24;
  localparam int PCNT_W  = 9;

  // command kinds passed from parser to span stage
  localparam logic [1:0] KIND_PAL  = 2'd0;
  localparam logic [1:0] KIND_SPAN = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NIBBLE_MODE   = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         count;
    logic [7:0]         idx0;
    logic [7:0]         idx1;
    logic               eob;
    logic [COLOR_W-1:0] color;
  } brle_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  line_width;
    logic [PCNT_W-1:0] palette_count;
  } brle_cfg_t;

endpackage

FILE: rtl/core/brle_ram.sv
// ---------------------------------------------------------------------------
// brle_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module brle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/brle_front.sv
// ---------------------------------------------------------------------------
// brle_front
// byte parser: tracks rle phase; palette writes, run values, literal bytes and escape ends give a command
// ---------------------------------------------------------------------------
module brle_front import brle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               nibble_mode,
  input  logic               accept,
  input  logic               mode,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         palette_index,
  input  logic [COLOR_W-1:0] palette_color,
  output logic               push,
  output brle_cmd_t          cmd
);

  localparam logic [2:0] PH_COUNT  = 3'd0;
  localparam logic [2:0] PH_VALUE  = 3'd1;
  localparam logic [2:0] PH_ESCAPE = 3'd2;
  localparam logic [2:0] PH_DX     = 3'd3;
  localparam logic [2:0] PH_DY     = 3'd4;
  localparam logic [2:0] PH_ABS    = 3'd5;
  localparam logic [2:0] PH_PAD    = 3'd6;

  logic [2:0] phase, phase_next;
  logic [7:0] run_length, run_length_next;
  logic [7:0] abs_rem, abs_rem_next;
  logic       pad_pending, pad_pending_next;
  logic [7:0] delta_dx, delta_dx_next;
  logic [7:0] abs_n;
  logic [8:0] odd_sum;
  logic [7:0] hi_idx, lo_idx;

  assign hi_idx  = {4'd0, data_byte[7:4]};
  assign lo_idx  = {4'd0, data_byte[3:0]};
  assign odd_sum = {1'b0, data_byte} + 9'd1;

  // pixels taken by one absolute byte
  always_comb begin
    if (nibble_mode) begin
      abs_n = (abs_rem >= 8'd2) ? 8'd2 : abs_rem;
    end else begin
      abs_n = (abs_rem >= 8'd1) ? 8'd1 : 8'd0;
    end
  end

  // parser next state and command
  always_comb begin
    phase_next       = phase;
    run_length_next  = run_length;
    abs_rem_next     = abs_rem;
    pad_pending_next = pad_pending;
    delta_dx_next    = delta_dx;
    push             = 1'b0;
    cmd              = '0;
    if (accept) begin
      if (!mode) begin
        push      = 1'b1;
        cmd.kind  = KIND_PAL;
        cmd.idx0  = palette_index;
        cmd.color = palette_color;
      end else begin
        unique case (phase)
          PH_COUNT: begin
            if (data_byte == 8'd0) begin
              phase_next = PH_ESCAPE;
            end else begin
              run_length_next = data_byte;
              phase_next      = PH_VALUE;
            end
          end
          PH_VALUE: begin
            phase_next = PH_COUNT;
            push       = 1'b1;
            cmd.kind   = KIND_SPAN;
            cmd.count  = run_length;
            cmd.idx0   = nibble_mode ? hi_idx : data_byte;
            cmd.idx1   = nibble_mode ? lo_idx : data_byte;
          end
          PH_ESCAPE: begin
            if (data_byte == 8'd0 || data_byte == 8'd1) begin
              phase_next = PH_COUNT;
              push       = 1'b1;
              cmd.kind   = KIND_EOL;
              cmd.eob    = data_byte[0];
            end else if (data_byte == 8'd2) begin
              phase_next = PH_DX;
            end else begin
              abs_rem_next     = data_byte;
              pad_pending_next = nibble_mode ? odd_sum[1] : data_byte[0];
              phase_next       = PH_ABS;
            end
          end
          PH_DX: begin
            delta_dx_next = data_byte;
            phase_next    = PH_DY;
          end
          PH_DY: begin
            phase_next = PH_COUNT;
            push       = 1'b1;
            cmd.kind   = KIND_SPAN;
            cmd.count  = delta_dx;
          end
          PH_ABS: begin
            abs_rem_next = abs_rem - abs_n;
            if (abs_rem_next == 8'd0) begin
              phase_next = pad_pending ? PH_PAD : PH_COUNT;
            end
            push      = 1'b1;
            cmd.kind  = KIND_SPAN;
            cmd.count = abs_n;
            cmd.idx0  = nibble_mode ? hi_idx : data_byte;
            cmd.idx1  = nibble_mode ? ((abs_n >= 8'd2) ? lo_idx : hi_idx) : data_byte;
          end
          PH_PAD: begin
            pad_pending_next = 1'b0;
            phase_next       = PH_COUNT;
          end
          default: begin
            phase_next = PH_COUNT;
          end
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_COUNT;
      run_length  <= 8'd0;
      abs_rem     <= 8'd0;
      pad_pending <= 1'b0;
      delta_dx    <= 8'd0;
    end else begin
      phase       <= phase_next;
      run_length  <= run_length_next;
      abs_rem     <= abs_rem_next;
      pad_pending <= pad_pending_next;
      delta_dx    <= delta_dx_next;
    end
  end

endmodule

FILE: rtl/core/brle_queue.sv
// ---------------------------------------------------------------------------
// brle_queue
// four entry command queue between parser and span stage
// ---------------------------------------------------------------------------
module brle_queue import brle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  brle_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output brle_cmd_t head_cmd
);

  brle_cmd_t  slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;

  assign full       = (fill == 3'd4);
  assign head_valid = (fill != 3'd0);
  assign head_cmd   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill + {2'd0, push} - {2'd0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");

endmodule

FILE: rtl/core/brle_back.sv
// ---------------------------------------------------------------------------
// brle_back
// palette lookup, column tracking, clipping and the output register
// ---------------------------------------------------------------------------
module brle_back import brle_pkg::*; #(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  brle_cfg_t          cfg,
  input  logic               head_valid,
  input  brle_cmd_t          head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COL_W-1:0]   start_column,
  output logic [COL_W-1:0]   pixel_count,
  output logic [COLOR_W-1:0] first_color,
  output logic [COLOR_W-1:0] second_color,
  output logic               line_end,
  output logic               bitmap_end
);

  localparam int          AW   = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0]  PENT = 9'(PALETTE_ENTRIES);
  localparam logic [14:0] MAXW = 15'(MAX_WIDTH);

  logic [COL_W-1:0] column, column_next;
  logic [COL_W-1:0] eff_w, room, cnt;
  logic [14:0]      lw_ext;
  logic             s2_valid, s2_go, s2_emit, o_free;
  logic [1:0]       s2_kind;
  logic [7:0]       s2_count;
  logic             s2_eob, s2_blk0, s2_blk1;
  logic [COLOR_W-1:0] rd0, rd1;
  logic             blk0, blk1, pal_we;

  // stage 1: palette read and write
  assign pop  = head_valid && (!s2_valid || s2_go);
  assign blk0 = ({1'b0, head_cmd.idx0} >= cfg.palette_count) || ({1'b0, head_cmd.idx0} >= PENT);
  assign blk1 = ({1'b0, head_cmd.idx1} >= cfg.palette_count) || ({1'b0, head_cmd.idx1} >= PENT);
  assign pal_we = pop && (head_cmd.kind == KIND_PAL) && ({1'b0, head_cmd.idx0} < PENT);

  brle_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal0 (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head_cmd.idx0[AW-1:0]),
    .wdata (head_cmd.color),
    .re    (pop),
    .raddr (head_cmd.idx0[AW-1:0]),
    .rdata (rd0)
  );

  brle_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal1 (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head_cmd.idx0[AW-1:0]),
    .wdata (head_cmd.color),
    .re    (pop),
    .raddr (head_cmd.idx1[AW-1:0]),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pop) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_kind  <= head_cmd.kind;
      s2_count <= head_cmd.count;
      s2_eob   <= head_cmd.eob;
      s2_blk0  <= blk0;
      s2_blk1  <= blk1;
    end
  end

  // stage 2: clip against the line width
  assign lw_ext = {2'd0, cfg.line_width};
  assign eff_w  = (lw_ext > MAXW) ? MAXW[COL_W-1:0] : cfg.line_width;
  assign room   = (column < eff_w) ? (eff_w - column) : '0;

  always_comb begin
    cnt         = room;
    column_next = column;
    s2_emit     = 1'b0;
    unique case (s2_kind)
      KIND_SPAN: begin
        cnt         = ({5'd0, s2_count} < room) ? {5'd0, s2_count} : room;
        s2_emit     = (cnt != '0);
        column_next = column + cnt;
      end
      KIND_EOL: begin
        s2_emit     = 1'b1;
        column_next = '0;
      end
      default: begin
        s2_emit = 1'b0;
      end
    endcase
  end

  assign o_free = !out_valid || !out_stall;
  assign s2_go  = s2_valid && (!s2_emit || o_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (s2_go) begin
      column <= column_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s2_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_emit) begin
      start_column <= column;
      pixel_count  <= cnt;
      first_color  <= s2_blk0 ? '0 : rd0;
      second_color <= s2_blk1 ? '0 : rd1;
      line_end     <= (s2_kind == KIND_EOL);
      bitmap_end   <= (s2_kind == KIND_EOL) && s2_eob;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_end |-> pixel_count != '0)
    else $error("empty span delivered");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bitmap_end |-> line_end)
    else $error("bitmap end without line end");
  assert property (@(posedge clk) disable iff (rst)
    s2_go && s2_kind == KIND_EOL |=> column == '0)
    else $error("column not cleared at line end");

endmodule

FILE: rtl/core/bmp_rle_span_decoder.sv
// ---------------------------------------------------------------------------
// bmp_rle_span_decoder
// rle8 / rle4 bitmap decoder producing coloured pixel spans
// ---------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_stall  mode, data_byte, palette_index, palette_color
//  out      out_valid/out_stall start_column, pixel_count, first_color,
//                              second_color, line_end, bitmap_end
//  cfg      apb write/read     nibble_mode, line_width, palette_count
//
// one item per cycle sustained while in_stall is low; an accepted item passes
// through a queue slot, the palette ram read and the output register to the output.
// the four entry command queue absorbs output stalls; in_stall rises when it is full.
// reset clears parser phase, column, queue and valid flags; the palette is
// undefined until written.
// ---------------------------------------------------------------------------
module bmp_rle_span_decoder import brle_pkg::*; #(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         palette_index,
  input  logic [COLOR_W-1:0] palette_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COL_W-1:0]   start_column,
  output logic [COL_W-1:0]   pixel_count,
  output logic [COLOR_W-1:0] first_color,
  output logic [COLOR_W-1:0] second_color,
  output logic               line_end,
  output logic               bitmap_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic      nibble_mode;
  brle_cfg_t cfg;
  logic      accept, push, full, pop, head_valid, cfg_wr;
  brle_cmd_t push_cmd, head_cmd;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_mode       <= 1'b0;
      cfg.line_width    <= 13'd640;
      cfg.palette_count <= 9'd256;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_NIBBLE_MODE:   nibble_mode       <= pwdata[0];
        REG_LINE_WIDTH:    cfg.line_width    <= pwdata[COL_W-1:0];
        REG_PALETTE_COUNT: cfg.palette_count <= pwdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NIBBLE_MODE:   prdata = {31'd0, nibble_mode};
      REG_LINE_WIDTH:    prdata = {19'd0, cfg.line_width};
      REG_PALETTE_COUNT: prdata = {23'd0, cfg.palette_count};
      default:           prdata = 32'd0;
    endcase
  end

  // input handshake
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  brle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .nibble_mode   (nibble_mode),
    .accept        (accept),
    .mode          (mode),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_color (palette_color),
    .push          (push),
    .cmd           (push_cmd)
  );

  brle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  brle_back #(
    .MAX_WIDTH       (MAX_WIDTH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .start_column (start_column),
    .pixel_count  (pixel_count),
    .first_color  (first_color),
    .second_color (second_color),
    .line_end     (line_end),
    .bitmap_end   (bitmap_end)
  );

endmodule

FILE: dv/tb_bmp_rle_span_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bmp_rle_span_decoder
// self-checking bench for the bitmap rle8 / rle4 span decoder
// ---------------------------------------------------------------------------
// a queue of compressed bytes and palette writes feeds a clocked driver; a
// decoder model inside the bench predicts each span as its item is accepted
// and a clocked monitor compares the spans that leave the block. the run
// steps through several register settings, written over apb while idle,
// with random idling on both channels and one long output hold.
// ---------------------------------------------------------------------------
module tb_bmp_rle_span_decoder;
  import brle_pkg::*;

  localparam int WIDTH_CAP  = 4096;
  localparam int PAL_SIZE   = 256;
  localparam int DRAIN_WAIT = 12;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [2:0] {
    AT_COUNT, AT_VALUE, AT_ESCAPE, AT_DX, AT_DY, AT_LITERAL, AT_PAD
  } parse_state_e;

  typedef struct {
    logic               mode;
    logic [7:0]         data_byte;
    logic [7:0]         palette_index;
    logic [COLOR_W-1:0] palette_color;
  } stream_item_t;

  typedef struct {
    logic [COL_W-1:0]   start_column;
    logic [COL_W-1:0]   pixel_count;
    logic [COLOR_W-1:0] first_color;
    logic [COLOR_W-1:0] second_color;
    logic               line_end;
    logic               bitmap_end;
  } span_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic mode = 0;
  logic [7:0] data_byte = 0;
  logic [7:0] palette_index = 0;
  logic [COLOR_W-1:0] palette_color = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [COL_W-1:0] start_column;
  logic [COL_W-1:0] pixel_count;
  logic [COLOR_W-1:0] first_color;
  logic [COLOR_W-1:0] second_color;
  logic line_end;
  logic bitmap_end;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  bmp_rle_span_decoder u_dut (.*);

  always #2 clk = ~clk;

  // decoder copy held by the bench
  logic               cfg_nibble = 0;
  logic [COL_W-1:0]   cfg_width = 640;
  logic [PCNT_W-1:0]  cfg_pal_count = 256;
  parse_state_e       pstate = AT_COUNT;
  int unsigned        column = 0;
  int unsigned        run_len = 0;
  int unsigned        literal_left = 0;
  logic               pad_due = 0;
  int unsigned        skip_dx = 0;
  logic [COLOR_W-1:0] palette_copy [PAL_SIZE];

  stream_item_t pending_items[$];
  span_t        expected_spans[$];
  int           errors = 0;
  logic         hold_sender = 0;
  logic         no_idle = 0;
  logic         rx_hold_req = 0;
  logic         rx_hold_done = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           rx_hold = 0;
  int           quiet_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  function automatic logic [COLOR_W-1:0] colour_of(int unsigned idx);
    if (idx >= cfg_pal_count || idx >= PAL_SIZE) return '0;
    return palette_copy[idx];
  endfunction

  function automatic int unsigned clip_width();
    return (cfg_width > WIDTH_CAP) ? WIDTH_CAP : cfg_width;
  endfunction

  // clipped span at the current column, skipped when empty
  task automatic add_span(int unsigned n, logic [COLOR_W-1:0] c0, logic [COLOR_W-1:0] c1);
    int unsigned w, cnt;
    span_t s;
    w = clip_width();
    if (column >= w) return;
    cnt = (n < w - column) ? n : w - column;
    if (cnt == 0) return;
    s = '{column, cnt, c0, c1, 1'b0, 1'b0};
    column = column + cnt;
    expected_spans.push_back(s);
  endtask

  // expected spans for one accepted item
  task automatic decode_item(stream_item_t it);
    int unsigned b, w, n;
    logic [COLOR_W-1:0] c0, c1;
    span_t s;
    if (!it.mode) begin
      palette_copy[it.palette_index] = it.palette_color;
      return;
    end
    b = it.data_byte;
    case (pstate)
      AT_COUNT: begin
        if (b == 0) pstate = AT_ESCAPE;
        else begin
          run_len = b;
          pstate = AT_VALUE;
        end
      end
      AT_VALUE: begin
        pstate = AT_COUNT;
        if (cfg_nibble) begin
          c0 = colour_of(b >> 4);
          c1 = colour_of(b & 'h0F);
        end else begin
          c0 = colour_of(b);
          c1 = c0;
        end
        add_span(run_len, c0, c1);
      end
      AT_ESCAPE: begin
        if (b <= 1) begin
          w = clip_width();
          n = (column < w) ? w - column : 0;
          c0 = colour_of(0);
          s = '{column, n, c0, c0, 1'b1, (b == 1)};
          expected_spans.push_back(s);
          column = 0;
          pstate = AT_COUNT;
        end else if (b == 2) begin
          pstate = AT_DX;
        end else begin
          literal_left = b;
          pad_due = cfg_nibble ? 1'(((b + 1) >> 1) & 1) : 1'(b & 1);
          pstate = AT_LITERAL;
        end
      end
      AT_DX: begin
        skip_dx = b;
        pstate = AT_DY;
      end
      AT_DY: begin
        pstate = AT_COUNT;
        c0 = colour_of(0);
        add_span(skip_dx, c0, c0);
      end
      AT_LITERAL: begin
        if (cfg_nibble) begin
          n = (literal_left >= 2) ? 2 : literal_left;
          c0 = colour_of(b >> 4);
          c1 = (n >= 2) ? colour_of(b & 'h0F) : c0;
        end else begin
          n = (literal_left >= 1) ? 1 : 0;
          c0 = colour_of(b);
          c1 = c0;
        end
        literal_left = literal_left - n;
        if (literal_left == 0) pstate = pad_due ? AT_PAD : AT_COUNT;
        add_span(n, c0, c1);
      end
      AT_PAD: begin
        pad_due = 0;
        pstate = AT_COUNT;
      end
      default: pstate = AT_COUNT;
    endcase
  endtask

  // driver: input channel, prediction at acceptance
  always @(posedge clk) begin
    stream_item_t it;
    if (in_valid && !in_stall) begin
      it = '{mode, data_byte, palette_index, palette_color};
      decode_item(it);
    end
    if (!rst && (!in_valid || !in_stall)) begin
      if (tx_gap > 0 || hold_sender || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (tx_gap > 0) tx_gap <= tx_gap - 1;
      end else begin
        it = pending_items.pop_front();
        mode <= it.mode;
        data_byte <= it.data_byte;
        palette_index <= it.palette_index;
        palette_color <= it.palette_color;
        in_valid <= 1'b1;
        tx_gap <= pick_gap();
      end
    end
  end

  // receiver stall, with one long hold on request
  always @(posedge clk) begin
    if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done <= 1'b1;
      rx_hold <= 300;
      out_stall <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_stall <= 1'b1;
    end else begin
      rx_gap <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // monitor: compare spans with the oldest expectation
  always @(posedge clk) begin
    span_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        $error("span with nothing expected: start %0d count %0d", start_column, pixel_count);
        errors++;
      end else begin
        e = expected_spans.pop_front();
        if (start_column !== e.start_column) begin
          $error("start_column exp %0d got %0d", e.start_column, start_column); errors++;
        end
        if (pixel_count !== e.pixel_count) begin
          $error("pixel_count exp %0d got %0d", e.pixel_count, pixel_count); errors++;
        end
        if (first_color !== e.first_color) begin
          $error("first_color exp %h got %h", e.first_color, first_color); errors++;
        end
        if (second_color !== e.second_color) begin
          $error("second_color exp %h got %h", e.second_color, second_color); errors++;
        end
        if (line_end !== e.line_end) begin
          $error("line_end exp %0b got %0b", e.line_end, line_end); errors++;
        end
        if (bitmap_end !== e.bitmap_end) begin
          $error("bitmap_end exp %0b got %0b", e.bitmap_end, bitmap_end); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bmp_rle_span_decoder: mismatch");
      $finish;
    end
  end

  task automatic push_byte(int unsigned b);
    stream_item_t it;
    it = '{1'b1, b[7:0], 8'($urandom), 24'($urandom)};
    pending_items.push_back(it);
  endtask

  task automatic push_palette(int unsigned idx, int unsigned colour);
    stream_item_t it;
    it = '{1'b0, 8'($urandom), idx[7:0], colour[23:0]};
    pending_items.push_back(it);
  endtask

  task automatic push_literal(int unsigned n);
    int unsigned nbytes;
    nbytes = cfg_nibble ? (n + 1) / 2 : n;
    push_byte(0);
    push_byte(n);
    repeat (nbytes) push_byte($urandom_range(255));
    if (nbytes % 2) push_byte($urandom_range(255));
  endtask

  task automatic apb_write(logic [1:0] idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_regs(int unsigned nib, int unsigned w, int unsigned pc);
    apb_write(REG_NIBBLE_MODE, nib);
    apb_write(REG_LINE_WIDTH, w);
    apb_write(REG_PALETTE_COUNT, pc);
    cfg_nibble = nib[0];
    cfg_width = w[COL_W-1:0];
    cfg_pal_count = pc[PCNT_W-1:0];
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_spans.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // mostly well-formed sequences with random content, some noise
  task automatic random_stream(int unsigned n_items);
    int unsigned start, r;
    start = pending_items.size();
    while (pending_items.size() - start < n_items) begin
      r = $urandom_range(99);
      if (r < 35) begin
        push_byte($urandom_range(99) < 85 ? $urandom_range(20, 1) : $urandom_range(255, 1));
        push_byte($urandom_range(255));
      end else if (r < 55) begin
        push_literal($urandom_range(99) < 85 ? $urandom_range(12, 3) : $urandom_range(255, 3));
      end else if (r < 65) begin
        push_byte(0); push_byte(2);
        push_byte($urandom_range(255)); push_byte($urandom_range(255));
      end else if (r < 75) begin
        push_byte(0); push_byte($urandom_range(1));
      end else if (r < 82) begin
        push_palette($urandom_range(255), $urandom);
      end else begin
        push_byte($urandom_range(255));
      end
    end
  endtask

  initial begin
    int unsigned nib_set [5] = '{1, 0, 1, 0, 1};
    int unsigned wid_set [5] = '{4096, 1, 7, 4096, 33};
    int unsigned pc_set [5] = '{256, 0, 16, 255, 5};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // registers first, while nothing is in flight
    set_regs(0, 640, 256);
    // fill the whole palette so no lookup reads an unwritten entry
    for (int i = 0; i < PAL_SIZE; i++) push_palette(i, $urandom);

    // directed: field extremes, each escape and run kind
    push_palette(255, 'hFFFFFF);
    push_palette(0, 0);
    push_byte(255); push_byte(255);
    push_byte(1); push_byte(0);
    push_byte(0); push_byte(2); push_byte(255); push_byte(0);
    push_literal(3);
    push_byte(255); push_byte(128);
    push_byte(255); push_byte(7);
    push_byte(0); push_byte(0);
    push_byte(0); push_byte(1);
    push_byte(0); push_byte(0);
    drain();

    // directed rle4 with an odd literal and an overrun
    set_regs(1, 5, 256);
    push_byte(9); push_byte('hAB);
    push_byte(0); push_byte(0);
    push_literal(5);
    push_byte(0); push_byte(1);
    drain();

    // random phases over several settings, one with no idling
    for (int p = 0; p < 6; p++) begin
      if (p < 5) set_regs(nib_set[p], wid_set[p], pc_set[p]);
      else set_regs($urandom_range(1), $urandom_range(4096, 1), $urandom_range(256));
      no_idle = (p == 2);
      if (p == 1) begin
        random_stream(60);
        while (pending_items.size() > 40) @(posedge clk);
        rx_hold_req = 1'b1;
      end
      random_stream(200);
      drain();
    end

    // sender pauses with results still in flight
    random_stream(40);
    while (pending_items.size() > 20) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_spans.size() != 0 || in_valid) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    if (errors == 0) $display("bmp_rle_span_decoder: match");
    else $display("bmp_rle_span_decoder: mismatch");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/brle_pkg.sv
rtl/core/brle_ram.sv
rtl/core/brle_front.sv
rtl/core/brle_queue.sv
rtl/core/brle_back.sv
rtl/core/bmp_rle_span_decoder.sv
dv/tb_bmp_rle_span_decoder.sv
